// ===== src/tleq_pkg.sv =====
// shared constants and types for the two-level event queue
package tleq_pkg;

	localparam int RING_DEPTH = 64;
	localparam int EVENT_BITS = 16;
	localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	typedef enum logic [1:0] {
		MODE_POST_NORMAL  = 2'd0,
		MODE_POST_PREMIER = 2'd1,
		MODE_GET          = 2'd2,
		MODE_CHECK        = 2'd3
	} mode_t;

	typedef struct packed {
		logic post;
		logic pop;
		logic peek;
	} ring_cmd_t;

	typedef struct packed {
		logic empty;
	} ring_stat_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == '0) begin
			r = PTR_W'(RING_DEPTH - 1);
		end else begin
			r = p - PTR_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== src/tleq_ram.sv =====
// generic single-write, single-read ram with registered read data
module tleq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/tleq_ring.sv =====
// one event ring: head and tail pointers with overwrite of the oldest entry
module tleq_ring
	import tleq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ring_cmd_t             cmd,
	input  logic [EVENT_BITS-1:0] ev,
	output ring_stat_t            stat,
	output logic [EVENT_BITS-1:0] rdata
);

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] tail_nxt;
	logic [PTR_W-1:0] raddr;

	assign stat.empty = (head_q == tail_q);
	assign tail_nxt   = ptr_next(tail_q);
	assign raddr      = cmd.pop ? head_q : ptr_prev(tail_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (cmd.post) begin
				tail_q <= tail_nxt;
				if (tail_nxt == head_q) begin
					head_q <= ptr_next(head_q);
				end
			end else if (cmd.pop) begin
				head_q <= ptr_next(head_q);
			end
		end
	end

	tleq_ram #(
		.WIDTH (EVENT_BITS),
		.DEPTH (RING_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.post),
		.waddr (tail_q),
		.wdata (ev),
		.re    (cmd.pop | cmd.peek),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule

// ===== src/two_level_event_queue.sv =====
// top level of the two-level event queue
// Takes one item per cycle unless the s1 registers hold an item that cannot advance.
// Each item gives one result via the registered ring memory read, then the output
// register. An item may be accepted while a result waits in the output register.
// Posting to a full ring (RING_DEPTH-1 events) drops its oldest event. A get
// serves the premier ring before the normal ring. Rings are empty after reset.
module two_level_event_queue
	import tleq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // event_id
	input  logic [1:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // event_out, got_event, premier_match, zero fill
);

	mode_t                 mode;
	logic [EVENT_BITS-1:0] ev;
	logic                  accept;
	ring_cmd_t             p_cmd;
	ring_cmd_t             n_cmd;
	ring_stat_t            p_stat;
	ring_stat_t            n_stat;
	logic [EVENT_BITS-1:0] p_rdata;
	logic [EVENT_BITS-1:0] n_rdata;

	logic                  valid_s1;
	mode_t                 mode_s1;
	logic [EVENT_BITS-1:0] ev_s1;
	logic                  got_s1;
	logic                  from_prem_s1;
	logic                  prem_full_s1;
	logic                  adv_s1;

	logic                  out_valid_q;
	logic [15:0]           event_out_q;
	logic                  got_q;
	logic                  match_q;
	logic [15:0]           event_out_d;
	logic                  match_d;

	assign mode   = mode_t'(s_tuser);
	assign ev     = s_tdata[EVENT_BITS-1:0];
	assign adv_s1 = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign accept = s_tvalid && s_tready;

	assign p_cmd.post = accept && (mode == MODE_POST_PREMIER);
	assign p_cmd.pop  = accept && (mode == MODE_GET) && !p_stat.empty;
	assign p_cmd.peek = accept && (mode == MODE_CHECK);
	assign n_cmd.post = accept && (mode == MODE_POST_NORMAL);
	assign n_cmd.pop  = accept && (mode == MODE_GET) && p_stat.empty && !n_stat.empty;
	assign n_cmd.peek = 1'b0;

	tleq_ring u_premier (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (p_cmd),
		.ev     (ev),
		.stat   (p_stat),
		.rdata  (p_rdata)
	);

	tleq_ring u_normal (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (n_cmd),
		.ev     (ev),
		.stat   (n_stat),
		.rdata  (n_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1      <= mode;
			ev_s1        <= ev;
			got_s1       <= p_cmd.pop || n_cmd.pop;
			from_prem_s1 <= p_cmd.pop;
			prem_full_s1 <= !p_stat.empty;
		end
	end

	always_comb begin
		event_out_d = '0;
		if (got_s1) begin
			event_out_d = from_prem_s1 ? 16'(p_rdata) : 16'(n_rdata);
		end
		match_d = (mode_s1 == MODE_CHECK) && prem_full_s1 && (p_rdata == ev_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			event_out_q <= event_out_d;
			got_q       <= got_s1;
			match_q     <= match_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, match_q, got_q, event_out_q};

endmodule

// ===== tb/sv/two_level_event_queue_tb.sv =====
// testbench for the two-level event queue: directed and random items checked against a predictor
`timescale 1ns / 100ps

module two_level_event_queue_tb;
	import tleq_pkg::*;

	localparam int NORMAL_SIDE  = 0;
	localparam int PREMIER_SIDE = 1;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 250;
	localparam int RANDOM_ITEMS = 1450;
	localparam logic [15:0] EVENT_MASK = 16'((64'd1 << EVENT_BITS) - 64'd1);

	typedef struct packed {
		logic        premier_match;
		logic        got_event;
		logic [15:0] event_out;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // event_id
	logic [1:0]  s_tuser = '0;   // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // event_out, got_event, premier_match, zero fill

	logic [15:0]      ring_mem [2][RING_DEPTH];
	logic [PTR_W-1:0] ring_head [2];
	logic [PTR_W-1:0] ring_tail [2];

	queue_result_t pending_results[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_left = 0;
	int stall_left = 0;
	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;

	two_level_event_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [PTR_W-1:0] advance_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] retreat_ptr(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - PTR_W'(1);
	endfunction

	function automatic bit ring_holds(input int side);
		return ring_head[side] != ring_tail[side];
	endfunction

	function automatic queue_result_t queue_response(input mode_t op, input logic [15:0] id);
		queue_result_t res;
		logic [15:0]   ev;
		int            side;
		res = '0;
		ev = id & EVENT_MASK;
		unique case (op)
			MODE_POST_NORMAL, MODE_POST_PREMIER: begin
				side = (op == MODE_POST_PREMIER) ? PREMIER_SIDE : NORMAL_SIDE;
				ring_mem[side][ring_tail[side]] = ev;
				ring_tail[side] = advance_ptr(ring_tail[side]);
				if (ring_tail[side] == ring_head[side]) begin
					ring_head[side] = advance_ptr(ring_head[side]);
				end
			end
			MODE_GET: begin
				side = ring_holds(PREMIER_SIDE) ? PREMIER_SIDE :
					ring_holds(NORMAL_SIDE) ? NORMAL_SIDE : -1;
				if (side >= 0) begin
					res.event_out = ring_mem[side][ring_head[side]];
					res.got_event = 1'b1;
					ring_head[side] = advance_ptr(ring_head[side]);
				end
			end
			default: begin
				if (ring_holds(PREMIER_SIDE) &&
					ring_mem[PREMIER_SIDE][retreat_ptr(ring_tail[PREMIER_SIDE])] == ev) begin
					res.premier_match = 1'b1;
				end
			end
		endcase
		return res;
	endfunction

	task automatic send_item(input mode_t op, input logic [15:0] id);
		int gap;
		gap = sender_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= id;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(queue_response(op, id));
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);
	endtask

	function automatic logic [15:0] random_event();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0) begin
			return 16'h0000;
		end else if (r == 1) begin
			return 16'hFFFF;
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	// result checker with receiver stalls and the long hold-off
	always @(posedge clk) begin
		queue_result_t want;
		queue_result_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen = queue_result_t'(m_tdata[17:0]);
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result %h at cycle %0d", m_tdata, cycle_count);
				end
			end else begin
				want = pending_results.pop_front();
				if (seen.event_out !== want.event_out || seen.got_event !== want.got_event ||
					seen.premier_match !== want.premier_match || m_tdata[23:18] !== '0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch at cycle %0d: expected ev %h got %b match %b, actual %h",
							cycle_count, want.event_out, want.got_event, want.premier_match,
							m_tdata);
					end
				end
			end
			stall_left = receiver_idle ? $urandom_range(0, 15) : 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_directed_cases();
		send_item(MODE_GET, 16'h1234);
		send_item(MODE_CHECK, 16'h0000);
		send_item(MODE_POST_NORMAL, 16'h0000);
		send_item(MODE_POST_NORMAL, 16'hFFFF);
		send_item(MODE_CHECK, 16'h0000);
		send_item(MODE_POST_PREMIER, 16'hFFFF);
		send_item(MODE_CHECK, 16'hFFFF);
		send_item(MODE_CHECK, 16'h0000);
		send_item(MODE_CHECK, 16'hFFFE);
		send_item(MODE_GET, 16'hFFFF);
		send_item(MODE_CHECK, 16'hFFFF);
		send_item(MODE_GET, 16'h0000);
		send_item(MODE_GET, 16'hFFFF);
		send_item(MODE_GET, 16'h0000);
		send_item(MODE_POST_PREMIER, 16'h8000);
		send_item(MODE_POST_PREMIER, 16'h0001);
		send_item(MODE_POST_NORMAL, 16'h5555);
		send_item(MODE_CHECK, 16'h8000);
		send_item(MODE_CHECK, 16'h0001);
		send_item(MODE_GET, 16'hAAAA);
		send_item(MODE_GET, 16'h0000);
		send_item(MODE_GET, 16'h0000);
		send_item(MODE_GET, 16'h0000);
	endtask

	// wrap both rings past full so the oldest events are dropped
	task automatic test_ring_overflow();
		repeat (RING_DEPTH + 6) send_item(MODE_POST_PREMIER, random_event());
		send_item(MODE_CHECK, ring_mem[PREMIER_SIDE][retreat_ptr(ring_tail[PREMIER_SIDE])]);
		repeat (2 * RING_DEPTH + 2) send_item(MODE_POST_NORMAL, random_event());
		repeat (2 * RING_DEPTH + 4) send_item(MODE_GET, random_event());
	endtask

	task automatic test_output_backpressure();
		wait_for_drain();
		sender_idle = 1'b0;
		hold_left = HOLD_CYCLES;
		repeat (20) send_item(MODE_POST_PREMIER, random_event());
		repeat (20) send_item(MODE_GET, random_event());
		wait_for_drain();
		sender_idle = 1'b1;
	endtask

	task automatic test_random_traffic(input int n_items);
		int    done;
		int    bias;
		int    r;
		int    lim_n;
		int    lim_p;
		int    lim_g;
		mode_t op;
		logic [15:0] id;
		done = 0;
		while (done < n_items) begin
			bias = $urandom_range(0, 2);
			sender_idle = ($urandom_range(0, 3) != 0);
			receiver_idle = ($urandom_range(0, 3) != 0);
			unique case (bias)
				0: begin
					lim_n = 35; lim_p = 70; lim_g = 85;
				end
				1: begin
					lim_n = 10; lim_p = 20; lim_g = 80;
				end
				default: begin
					lim_n = 25; lim_p = 50; lim_g = 75;
				end
			endcase
			for (int i = 0; i < 60 && done < n_items; i++) begin
				r = $urandom_range(0, 99);
				op = (r < lim_n) ? MODE_POST_NORMAL : (r < lim_p) ? MODE_POST_PREMIER :
					(r < lim_g) ? MODE_GET : MODE_CHECK;
				id = random_event();
				if (op == MODE_CHECK && $urandom_range(0, 1) == 1) begin
					id = ring_mem[PREMIER_SIDE][retreat_ptr(ring_tail[PREMIER_SIDE])];
				end
				send_item(op, id);
				done++;
			end
			if ($urandom_range(0, 4) == 0) begin
				wait_for_drain();
			end
		end
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
	endtask

	initial begin
		ring_head = '{default: '0};
		ring_tail = '{default: '0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_ring_overflow();
		test_output_backpressure();
		test_random_traffic(RANDOM_ITEMS);
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
